@@ rtl/core/mbrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrs_pkg
// Shared constants, function codes and helper functions for the Modbus RTU
// slave frame handler.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrs_pkg;

  // Default sizes of the stores
  localparam int DEF_HOLDING_COUNT = 10;
  localparam int DEF_INPUT_COUNT   = 5;
  localparam int DEF_BIT_COUNT     = 64;
  localparam int DEF_FRAME_BYTES   = 256;
  localparam int DEF_MAX_READ_REGS = 125;

  // Response length counter width (body plus CRC fits comfortably)
  localparam int RESP_W = 10;

  // Function codes
  localparam logic [7:0] FN_READ_COILS    = 8'h01;
  localparam logic [7:0] FN_READ_DISCRETE = 8'h02;
  localparam logic [7:0] FN_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FN_READ_INPUT    = 8'h04;
  localparam logic [7:0] FN_WRITE_COIL    = 8'h05;
  localparam logic [7:0] FN_WRITE_REG     = 8'h06;
  localparam logic [7:0] FN_WRITE_REGS    = 8'h10;

  // Exception codes
  localparam logic [7:0] EX_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0] EX_ILLEGAL_ADDRESS  = 8'h02;
  localparam logic [7:0] EX_ILLEGAL_VALUE    = 8'h03;
  localparam logic [7:0] EXC_FLAG            = 8'h80;

  // Coil write values and read limit
  localparam logic [15:0] COIL_ON      = 16'hFF00;
  localparam logic [15:0] COIL_OFF     = 16'h0000;
  localparam logic [16:0] MAX_BIT_READ = 17'd2000;

  // CRC-16 (reflected)
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Reset pattern of the coil and discrete bits, repeated every 8 bytes
  localparam logic [7:0] BIT_PATTERN [8] = '{8'hA5, 8'hCC, 8'hF0, 8'h0F,
                                             8'hA5, 8'hA5, 8'hA5, 8'hA5};

  // Advance the CRC by one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Holding register reset value
  function automatic logic [15:0] hold_init(input int k);
    return (k < 5) ? 16'(15 * (k + 1)) : 16'h0000;
  endfunction

  // Input register value (read only)
  function automatic logic [15:0] input_init(input int k);
    return (k < 5) ? 16'(10 + 5 * k) : 16'h0000;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mbrs_ram.sv @@
// ----------------------------------------------------------------------------
// mbrs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/modbus_rtu_slave_frame_handler.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_handler
// Modbus RTU slave: buffers a request frame, checks it and emits the response.
// ----------------------------------------------------------------------------
// Usage:
//   Request bytes enter on rx_byte with start; a byte is taken at a clock edge
//   with start high and busy low. frame_end marks the last byte of a frame.
//   Plain bytes leave busy low. The end byte raises busy: the frame RAM is
//   read back one byte a cycle to check the CRC, a decision state decides the
//   request, a write-multiple request reads its data back, then the response
//   goes out one word a cycle on tx_byte with tx_valid for a single cycle
//   each, the CRC low byte before high, tx_last on the final word. Busy drops
//   with the last word; frames that draw no answer end after the decision state.
//   The receiver cannot stall the response stream.
//   The user must write slave_address with cfg_write only while the block is
//   idle; the block itself does not enforce this.
//   Reset (rst, synchronous) restores the stores to their initial values and
//   empties the frame buffer; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_slave_frame_handler #(
  parameter int HOLDING_COUNT = mbrs_pkg::DEF_HOLDING_COUNT,
  parameter int INPUT_COUNT   = mbrs_pkg::DEF_INPUT_COUNT,
  parameter int BIT_COUNT     = mbrs_pkg::DEF_BIT_COUNT,
  parameter int FRAME_BYTES   = mbrs_pkg::DEF_FRAME_BYTES,
  parameter int MAX_READ_REGS = mbrs_pkg::DEF_MAX_READ_REGS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_end,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            tx_last
);

  import mbrs_pkg::*;

  localparam int AW        = $clog2(FRAME_BYTES);
  localparam int LW        = $clog2(FRAME_BYTES + 1);
  localparam int HW        = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
  localparam int IW        = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int BIT_BYTES = (BIT_COUNT + 7) / 8;
  localparam int BV        = BIT_BYTES * 8 + 8;
  localparam int BVW       = $clog2(BV);
  localparam int BW        = $clog2(BIT_BYTES * 8);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_WRMULT = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  localparam logic [1:0] RK_EXC  = 2'd0;
  localparam logic [1:0] RK_ECHO = 2'd1;
  localparam logic [1:0] RK_BITS = 2'd2;
  localparam logic [1:0] RK_REGS = 2'd3;

  logic [2:0]         state;
  logic [7:0]         slave_address;
  logic [LW-1:0]      frame_length;
  logic               frame_overflow;
  logic [LW-1:0]      proc_len;
  logic               proc_ovf;
  logic [LW-1:0]      rd_ptr;
  logic [LW-1:0]      rd_lim;
  logic               rv;
  logic [LW-1:0]      ridx;
  logic [7:0]         hdr [7];
  logic [15:0]        crc;
  logic [15:0]        got;
  logic [7:0]         hi_byte;
  logic [1:0]         kind;
  logic               src_alt;
  logic [7:0]         code;
  logic [RESP_W-1:0]  resp_len;
  logic [RESP_W-1:0]  idx;
  logic [15:0]        holding [HOLDING_COUNT];
  logic [BIT_BYTES*8-1:0] coil_bits;
  logic [BIT_BYTES*8-1:0] disc_bits;

  logic [7:0]         rd_data;
  logic               ram_we;
  logic               accept;
  logic               rd_go;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && (frame_length < LW'(FRAME_BYTES));
  assign rd_go  = (state == S_SCAN || state == S_WRMULT) && (rd_ptr < rd_lim);

  // Frame buffer
  mbrs_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(frame_length[AW-1:0]),
    .wdata(rx_byte),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(rd_data)
  );

  // Discrete inputs are fixed
  for (genvar g = 0; g < BIT_BYTES; g++) begin : g_disc
    assign disc_bits[8*g +: 8] = BIT_PATTERN[g % 8];
  end

  // Request fields
  logic [15:0] start_a, cnt;
  logic [7:0]  fn, bc;
  assign fn      = hdr[1];
  assign start_a = {hdr[2], hdr[3]};
  assign cnt     = {hdr[4], hdr[5]};
  assign bc      = hdr[6];

  // Decide the request
  logic [16:0]       sum_sc, nb;
  logic              dec_silent, dec_wrmult, dec_wr_coil, dec_wr_reg;
  logic [1:0]        dec_kind;
  logic              dec_alt;
  logic [7:0]        dec_code;
  logic [RESP_W-1:0] dec_len;

  always_comb begin
    sum_sc      = {1'b0, start_a} + {1'b0, cnt};
    nb          = ({1'b0, cnt} + 17'd7) >> 3;
    dec_silent  = 1'b0;
    dec_wrmult  = 1'b0;
    dec_wr_coil = 1'b0;
    dec_wr_reg  = 1'b0;
    dec_kind    = RK_EXC;
    dec_alt     = 1'b0;
    dec_code    = EX_ILLEGAL_FUNCTION;
    dec_len     = RESP_W'(3);
    priority if (proc_ovf || proc_len < LW'(4) || hdr[0] != slave_address ||
                 crc != got) begin
      dec_silent = 1'b1;
    end else if (fn >= FN_READ_COILS && fn <= FN_WRITE_REG &&
                 proc_len != LW'(8)) begin
      dec_silent = 1'b1;
    end else if (fn == FN_READ_COILS || fn == FN_READ_DISCRETE) begin
      dec_alt = (fn == FN_READ_DISCRETE);
      priority if (cnt == 16'd0 || {1'b0, cnt} > MAX_BIT_READ) begin
        dec_code = EX_ILLEGAL_VALUE;
      end else if (sum_sc > 17'(BIT_COUNT)) begin
        dec_code = EX_ILLEGAL_ADDRESS;
      end else begin
        dec_kind = RK_BITS;
        dec_len  = RESP_W'(nb + 17'd3);
      end
    end else if (fn == FN_READ_HOLDING || fn == FN_READ_INPUT) begin
      dec_alt = (fn == FN_READ_INPUT);
      priority if (cnt == 16'd0 || {1'b0, cnt} > 17'(MAX_READ_REGS) ||
                   {cnt, 1'b0} > 17'(FRAME_BYTES - 5)) begin
        dec_code = EX_ILLEGAL_VALUE;
      end else if (sum_sc > (dec_alt ? 17'(INPUT_COUNT) : 17'(HOLDING_COUNT))) begin
        dec_code = EX_ILLEGAL_ADDRESS;
      end else begin
        dec_kind = RK_REGS;
        dec_len  = RESP_W'({cnt, 1'b0} + 17'd3);
      end
    end else if (fn == FN_WRITE_COIL) begin
      priority if ({1'b0, start_a} >= 17'(BIT_COUNT)) begin
        dec_code = EX_ILLEGAL_ADDRESS;
      end else begin
        dec_wr_coil = 1'b1;
        dec_kind    = RK_ECHO;
        dec_len     = RESP_W'(6);
      end
    end else if (fn == FN_WRITE_REG) begin
      priority if ({1'b0, start_a} >= 17'(HOLDING_COUNT)) begin
        dec_code = EX_ILLEGAL_ADDRESS;
      end else begin
        dec_wr_reg = 1'b1;
        dec_kind   = RK_ECHO;
        dec_len    = RESP_W'(6);
      end
    end else if (fn == FN_WRITE_REGS) begin
      priority if (proc_len < LW'(9)) begin
        dec_silent = 1'b1;
      end else if ({1'b0, bc} != {cnt[7:0], 1'b0} || cnt[15:8] != 8'h00 ||
                   cnt == 16'd0 || {1'b0, cnt} > 17'(HOLDING_COUNT) ||
                   {1'b0, proc_len} != LW'(9) + {1'b0, LW'(bc)}) begin
        dec_code = EX_ILLEGAL_VALUE;
      end else if (sum_sc > 17'(HOLDING_COUNT)) begin
        dec_code = EX_ILLEGAL_ADDRESS;
      end else begin
        dec_wrmult = 1'b1;
        dec_kind   = RK_ECHO;
        dec_len    = RESP_W'(6);
      end
    end else begin
      dec_code = EX_ILLEGAL_FUNCTION;
    end
  end

  // Response byte for the current index
  logic [RESP_W-1:0] j;
  logic [16:0]       bit_a, rem, reg_k;
  logic [BV-1:0]     bit_src;
  logic [7:0]        bit_byte, bit_mask, body;
  logic [15:0]       reg_val;
  logic [RESP_W-1:0] last_idx;

  always_comb begin
    j        = idx - RESP_W'(3);
    bit_a    = {1'b0, start_a} + 17'({j, 3'b000});
    rem      = {1'b0, cnt} - 17'({j, 3'b000});
    bit_src  = {8'h00, (src_alt ? disc_bits : coil_bits)};
    bit_mask = (rem >= 17'd8) ? 8'hFF : (8'hFF >> (4'd8 - 4'(rem[3:0])));
    bit_byte = bit_src[bit_a[BVW-1:0] +: 8] & bit_mask;
    reg_k    = {1'b0, start_a} + 17'(j >> 1);
    reg_val  = src_alt ? input_init(int'(reg_k[IW-1:0])) : holding[reg_k[HW-1:0]];
    last_idx = resp_len + RESP_W'(1);
    priority if (idx == RESP_W'(0)) begin
      body = hdr[0];
    end else if (idx == RESP_W'(1)) begin
      body = (kind == RK_EXC) ? (hdr[1] | EXC_FLAG) : hdr[1];
    end else if (idx == RESP_W'(2)) begin
      unique case (kind)
        RK_EXC:  body = code;
        RK_ECHO: body = hdr[2];
        RK_BITS: body = nb[7:0];
        RK_REGS: body = {cnt[6:0], 1'b0};
        default: body = code;
      endcase
    end else begin
      unique case (kind)
        RK_ECHO: body = hdr[3'(idx[2:0])];
        RK_BITS: body = bit_byte;
        RK_REGS: body = j[0] ? reg_val[7:0] : reg_val[15:8];
        default: body = code;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slave_address  <= 8'd1;
      frame_length   <= '0;
      frame_overflow <= 1'b0;
      rv             <= 1'b0;
      tx_valid       <= 1'b0;
      for (int k = 0; k < HOLDING_COUNT; k++) begin
        holding[k] <= hold_init(k);
      end
      for (int k = 0; k < BIT_BYTES; k++) begin
        coil_bits[8*k +: 8] <= BIT_PATTERN[k % 8];
      end
    end else begin
      tx_valid <= (state == S_EMIT);
      if (cfg_write) begin
        slave_address <= cfg_data;
      end

      // Read pipeline of the frame RAM
      rv   <= rd_go;
      ridx <= rd_ptr;
      if (rd_go) begin
        rd_ptr <= rd_ptr + LW'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (frame_end) begin
              proc_len       <= ram_we ? frame_length + LW'(1) : frame_length;
              rd_lim         <= ram_we ? frame_length + LW'(1) : frame_length;
              proc_ovf       <= frame_overflow || !ram_we;
              frame_length   <= '0;
              frame_overflow <= 1'b0;
              rd_ptr         <= '0;
              crc            <= CRC_INIT;
              state          <= S_SCAN;
            end else if (ram_we) begin
              frame_length <= frame_length + LW'(1);
            end else begin
              frame_overflow <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // Capture header, run CRC, pick up the received CRC
          if (rv) begin
            if (ridx < LW'(7)) begin
              hdr[3'(ridx[2:0])] <= rd_data;
            end
            if (ridx + LW'(2) < proc_len) begin
              crc <= crc_byte(crc, rd_data);
            end
            if (ridx + LW'(2) == proc_len) begin
              got[7:0] <= rd_data;
            end
            if (ridx + LW'(1) == proc_len) begin
              got[15:8] <= rd_data;
              state     <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          kind     <= dec_kind;
          src_alt  <= dec_alt;
          code     <= dec_code;
          resp_len <= dec_len;
          idx      <= '0;
          crc      <= CRC_INIT;
          rd_ptr   <= LW'(7);
          rd_lim   <= LW'(7) + LW'(bc);
          if (dec_wr_coil) begin
            if (cnt == COIL_ON) begin
              coil_bits[start_a[BW-1:0]] <= 1'b1;
            end else if (cnt == COIL_OFF) begin
              coil_bits[start_a[BW-1:0]] <= 1'b0;
            end
          end
          if (dec_wr_reg) begin
            holding[start_a[HW-1:0]] <= cnt;
          end
          priority if (dec_silent) begin
            state <= S_IDLE;
          end else if (dec_wrmult) begin
            state <= S_WRMULT;
          end else begin
            state <= S_EMIT;
          end
        end
        S_WRMULT: begin
          // Odd offsets carry the high byte, even ones complete a register
          if (rv) begin
            if (ridx[0]) begin
              hi_byte <= rd_data;
            end else begin
              holding[HW'(start_a + 16'((ridx - LW'(8)) >> 1))] <= {hi_byte, rd_data};
            end
            if (ridx + LW'(1) == rd_lim) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          tx_last <= (idx == last_idx);
          priority if (idx == resp_len) begin
            tx_byte <= crc[7:0];
          end else if (idx == last_idx) begin
            tx_byte <= crc[15:8];
            state   <= S_IDLE;
          end else begin
            tx_byte <= body;
            crc     <= crc_byte(crc, body);
          end
          idx <= idx + RESP_W'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A final word is followed by a gap
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_last |=> !tx_valid)
    else $error("word after final response word");

  // The end byte of a frame makes the block busy
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && frame_end |=> busy)
    else $error("frame end not processed");

  // Fill count never exceeds the buffer
  a_fill: assert property (@(posedge clk) disable iff (rst)
    frame_length <= LW'(FRAME_BYTES))
    else $error("frame fill count beyond buffer");

  // Words other than the last one only go out while busy
  a_tx_busy: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_last |-> busy)
    else $error("response word while idle");
`endif

endmodule

`default_nettype wire
